// ----- design/dot_pkg.sv -----
// shared types, constants and helpers for the detector occupancy tracker
// no dependencies; imported by dot_if, dot_div and the top level
package dot_pkg;

  localparam int NumDetectorsDefault = 16;
  localparam int DetW     = 4;
  localparam int CntW     = 16;
  localparam int WinW     = 8;
  localparam int PctW     = 7;
  localparam int FactorW  = 9;
  localparam int MaskW    = 16;
  localparam int NumW     = 15;   // hold * 100 fits here
  localparam int DenW     = 9;    // hold + idle fits here
  localparam int ProdW    = 18;   // factor times signed difference
  localparam int AddrW    = 4;
  localparam int DataW    = 32;

  localparam logic [6:0]         Percent     = 7'd100;
  localparam logic [FactorW-1:0] Q8One       = 9'd256;
  localparam logic [FactorW-1:0] FactorReset = 9'd51;
  localparam logic [WinW-1:0]    WindowReset = 8'd10;

  typedef enum logic [1:0] {
    REG_FAULT_MASK   = 2'd0,
    REG_RISE_FACTOR  = 2'd1,
    REG_FALL_FACTOR  = 2'd2,
    REG_WINDOW_TICKS = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic            last;
    logic [CntW-1:0] rise_cnt;
    logic [CntW-1:0] fall_cnt;
    logic [WinW-1:0] hold;
    logic [WinW-1:0] idle;
    logic [PctW-1:0] occ;
    logic [PctW-1:0] smooth;
    logic [CntW-1:0] gap;
    logic [CntW-1:0] since_rise;
  } det_entry_t;

  function automatic logic [CntW-1:0] sat_inc16(input logic [CntW-1:0] v);
    return (&v) ? v : v + 1'b1;
  endfunction

  function automatic logic [WinW-1:0] sat_inc8(input logic [WinW-1:0] v);
    return (&v) ? v : v + 1'b1;
  endfunction

endpackage

// ----- design/dot_if.sv -----
// valid/ready channel interfaces for detector ticks and tracker results
// depends on dot_pkg for field widths
interface dot_in_if;
  import dot_pkg::*;
  logic            valid;
  logic            ready;
  logic [DetW-1:0] detector;
  logic            present;

  modport source (output valid, output detector, output present, input ready);
  modport sink   (input valid, input detector, input present, output ready);
endinterface

interface dot_out_if;
  import dot_pkg::*;
  logic            valid;
  logic            ready;
  logic [DetW-1:0] det_id;
  logic            occupied;
  logic [CntW-1:0] rising_count;
  logic [CntW-1:0] falling_count;
  logic [PctW-1:0] occupancy;
  logic [PctW-1:0] smoothed_occupancy;
  logic [CntW-1:0] gap_ticks;
  logic [CntW-1:0] since_rise_ticks;
  logic            window_done;
  logic            skipped_fault;

  modport source (
    output valid, output det_id, output occupied, output rising_count,
    output falling_count, output occupancy, output smoothed_occupancy,
    output gap_ticks, output since_rise_ticks, output window_done,
    output skipped_fault, input ready
  );
  modport sink (
    input valid, input det_id, input occupied, input rising_count,
    input falling_count, input occupancy, input smoothed_occupancy,
    input gap_ticks, input since_rise_ticks, input window_done,
    input skipped_fault, output ready
  );
endinterface

// ----- design/dot_div.sv -----
// iterative restoring divider, one quotient bit per cycle, for the occupancy percent
// depends on dot_pkg; quotient is known to stay below 128
module dot_div
  import dot_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [NumW-1:0] num_i,
  input  logic [DenW-1:0] den_i,
  output logic            done_o,
  output logic [PctW-1:0] quot_o
);

  localparam int RemW  = NumW + 1;
  localparam int StepW = $clog2(PctW);

  logic             busy_q;
  logic [StepW-1:0] step_q;
  logic [RemW-1:0]  rem_q;
  logic [DenW-1:0]  den_q;
  logic [PctW-1:0]  quot_q;
  logic             done_q;

  logic [RemW-1:0]  shifted;
  logic [RemW:0]    trial;

  assign shifted = RemW'(den_q) << step_q;
  assign trial   = {1'b0, rem_q} - {1'b0, shifted};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= StepW'(PctW - 1);
      end else if (busy_q) begin
        if (step_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          step_q <= step_q - 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= RemW'(num_i);
      den_q  <= den_i;
      quot_q <= '0;
    end else if (busy_q && !trial[RemW]) begin
      rem_q          <= trial[RemW-1:0];
      quot_q[step_q] <= 1'b1;
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

// ----- design/detector_occupancy_tracker_unit.sv -----
// Per-detector loop occupancy tracker. Takes one tick per beat on in_if and returns
// one result beat on out_if; ready drops while a tick is being worked. A tick that
// does not close a window goes through the update and emit states to the output
// register, and the next tick can be taken once the tracker returns to idle. A tick
// that closes one passes an update state, the shared divider that forms
// hold*100/(hold+idle) one quotient bit per cycle, its done pulse, a multiply state
// and an update state for the smoothed value, then the output register. A result
// held by out_if.ready stalls the tracker once the following tick is ready to emit.
// The next tick may be accepted while a result still waits.
// Depends on dot_pkg, dot_if and dot_div.
module detector_occupancy_tracker_unit
  import dot_pkg::*;
#(
  parameter int NumDetectors = NumDetectorsDefault
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready,
  dot_in_if.sink           in_if,
  dot_out_if.source        out_if
);

  localparam int IdxW = (NumDetectors > 1) ? $clog2(NumDetectors) : 1;

  typedef enum logic [2:0] {
    ST_IDLE, ST_UPDATE, ST_DIV, ST_SMOOTH, ST_APPLY, ST_EMIT
  } state_e;

  // configuration registers
  logic [MaskW-1:0]   fault_mask_q;
  logic [FactorW-1:0] rise_factor_q;
  logic [FactorW-1:0] fall_factor_q;
  logic [WinW-1:0]    window_q;
  reg_idx_e           reg_sel;

  assign reg_sel = reg_idx_e'(paddr[3:2]);
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fault_mask_q  <= '0;
      rise_factor_q <= FactorReset;
      fall_factor_q <= FactorReset;
      window_q      <= WindowReset;
    end else if (psel && penable && pwrite) begin
      unique case (reg_sel)
        REG_FAULT_MASK:   fault_mask_q  <= pwdata[MaskW-1:0];
        REG_RISE_FACTOR:  rise_factor_q <= pwdata[FactorW-1:0];
        REG_FALL_FACTOR:  fall_factor_q <= pwdata[FactorW-1:0];
        REG_WINDOW_TICKS: window_q      <= pwdata[WinW-1:0];
        default:          ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_FAULT_MASK:   prdata = DataW'(fault_mask_q);
      REG_RISE_FACTOR:  prdata = DataW'(rise_factor_q);
      REG_FALL_FACTOR:  prdata = DataW'(fall_factor_q);
      REG_WINDOW_TICKS: prdata = DataW'(window_q);
      default:          prdata = '0;
    endcase
  end

  // per-detector state
  det_entry_t st_q [NumDetectors];

  state_e            state_q;
  logic [DetW-1:0]   det_q;
  logic              present_q;
  logic              skip_q;
  logic              done_q;
  det_entry_t        ent_q;
  logic signed [ProdW-1:0] prod_q;

  logic              out_valid_q;
  det_entry_t        out_ent_q;
  logic [DetW-1:0]   out_det_q;
  logic              out_done_q;
  logic              out_skip_q;

  // tick update, evaluated in ST_UPDATE
  logic [IdxW-1:0]   idx;
  logic              in_range;
  logic              faulty;
  det_entry_t        cur;
  det_entry_t        upd;
  logic              rise_edge;
  logic              fall_edge;
  logic [DenW-1:0]   total;
  logic              win_full;

  assign idx      = IdxW'(det_q);
  assign in_range = 32'(det_q) < NumDetectors;
  assign faulty   = fault_mask_q[det_q];
  assign cur      = in_range ? st_q[idx] : '0;

  always_comb begin
    upd       = cur;
    rise_edge = present_q && !cur.last;
    fall_edge = !present_q && cur.last;
    if (rise_edge) upd.rise_cnt = sat_inc16(cur.rise_cnt);
    if (fall_edge) upd.fall_cnt = sat_inc16(cur.fall_cnt);
    // an edge restarts its timer, and this tick counts as the first
    upd.since_rise = rise_edge ? CntW'(1) : sat_inc16(cur.since_rise);
    upd.gap        = fall_edge ? CntW'(1) : sat_inc16(cur.gap);
    if (present_q) upd.hold = sat_inc8(cur.hold);
    else           upd.idle = sat_inc8(cur.idle);
    upd.last = present_q;
  end

  assign total    = DenW'(upd.hold) + DenW'(upd.idle);
  assign win_full = total >= DenW'(window_q);

  // divider for the window percent
  logic            div_start;
  logic            div_done;
  logic [PctW-1:0] div_quot;
  logic [NumW-1:0] div_num;

  assign div_start = (state_q == ST_UPDATE) && in_range && !faulty && win_full;
  assign div_num   = NumW'(upd.hold) * NumW'(Percent);

  dot_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (total),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  // smoothing: factor times signed difference
  logic signed [PctW:0]    diff;
  logic [FactorW-1:0]      fsel;
  logic [FactorW-1:0]      fclamp;
  logic signed [ProdW-1:0] prod_d;
  logic signed [ProdW-1:0] step;
  logic signed [PctW+2:0]  sm_sum;
  logic [PctW-1:0]         sm_new;

  assign diff   = $signed({1'b0, ent_q.occ}) - $signed({1'b0, ent_q.smooth});
  assign fsel   = (ent_q.occ > ent_q.smooth) ? rise_factor_q : fall_factor_q;
  assign fclamp = (fsel > Q8One) ? Q8One : fsel;
  assign prod_d = $signed({1'b0, fclamp}) * diff;

  // arithmetic shift gives the floor for negative products
  assign step   = prod_q >>> 8;
  assign sm_sum = $signed({3'b000, ent_q.smooth}) + step[PctW+2:0];

  always_comb begin
    if (sm_sum < 0)                              sm_new = '0;
    else if (sm_sum > $signed({3'b000, Percent})) sm_new = Percent;
    else                                         sm_new = sm_sum[PctW-1:0];
  end

  logic out_free;
  assign out_free = !out_valid_q || out_if.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      det_q       <= '0;
      present_q   <= 1'b0;
      skip_q      <= 1'b0;
      done_q      <= 1'b0;
      ent_q       <= '0;
      prod_q      <= '0;
      out_ent_q   <= '0;
      out_det_q   <= '0;
      out_done_q  <= 1'b0;
      out_skip_q  <= 1'b0;
      for (int i = 0; i < NumDetectors; i++) st_q[i] <= '0;
    end else begin
      if (out_valid_q && out_if.ready && (state_q != ST_EMIT)) out_valid_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (in_if.valid) begin
            det_q     <= in_if.detector;
            present_q <= in_if.present;
            state_q   <= ST_UPDATE;
          end
        end
        ST_UPDATE: begin
          done_q <= 1'b0;
          if (!in_range || faulty) begin
            skip_q  <= 1'b1;
            ent_q   <= cur;
            state_q <= ST_EMIT;
          end else begin
            skip_q  <= 1'b0;
            ent_q   <= upd;
            state_q <= win_full ? ST_DIV : ST_EMIT;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            ent_q.occ <= div_quot;
            state_q   <= ST_SMOOTH;
          end
        end
        ST_SMOOTH: begin
          prod_q  <= prod_d;
          state_q <= ST_APPLY;
        end
        ST_APPLY: begin
          ent_q.smooth <= sm_new;
          ent_q.hold   <= '0;
          ent_q.idle   <= '0;
          done_q       <= 1'b1;
          state_q      <= ST_EMIT;
        end
        ST_EMIT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_ent_q   <= ent_q;
            out_det_q   <= det_q;
            out_done_q  <= done_q;
            out_skip_q  <= skip_q;
            if (!skip_q) st_q[idx] <= ent_q;
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign in_if.ready = (state_q == ST_IDLE);

  assign out_if.valid              = out_valid_q;
  assign out_if.det_id             = out_det_q;
  assign out_if.occupied           = out_ent_q.last;
  assign out_if.rising_count       = out_ent_q.rise_cnt;
  assign out_if.falling_count      = out_ent_q.fall_cnt;
  assign out_if.occupancy          = out_ent_q.occ;
  assign out_if.smoothed_occupancy = out_ent_q.smooth;
  assign out_if.gap_ticks          = out_ent_q.gap;
  assign out_if.since_rise_ticks   = out_ent_q.since_rise;
  assign out_if.window_done        = out_done_q;
  assign out_if.skipped_fault      = out_skip_q;

endmodule
